/* sv/mst_pkg.sv */
`timescale 1ns / 1ps
package mst_pkg;

	localparam int ELEMS       = 16;
	localparam int STACK_DEPTH = 16;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW      = $clog2(STACK_DEPTH * ELEMS);
	localparam int CORDIC_STEPS = 20;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [33:0] FULL_TURN    = 34'sd23592960;
	localparam logic signed [33:0] HALF_TURN    = 34'sd11796480;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd5898240;
	localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

	localparam logic [3:0] CMD_IDENT = 4'd0;
	localparam logic [3:0] CMD_LOAD  = 4'd1;
	localparam logic [3:0] CMD_MUL   = 4'd2;
	localparam logic [3:0] CMD_ROT   = 4'd3;
	localparam logic [3:0] CMD_TRANS = 4'd4;
	localparam logic [3:0] CMD_SCALE = 4'd5;
	localparam logic [3:0] CMD_PUSH  = 4'd6;
	localparam logic [3:0] CMD_POP   = 4'd7;
	localparam logic [3:0] CMD_READ  = 4'd8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OVFL  = 2'd1;
	localparam logic [1:0] ST_UNDFL = 2'd2;

	// where a MAC result goes
	localparam logic [1:0] DST_CUR = 2'd0;
	localparam logic [1:0] DST_STK = 2'd1;
	localparam logic [1:0] DST_OUT = 2'd2;
	localparam logic [1:0] DST_REG = 2'd3;

	localparam logic [1:0] SEL_X = 2'd0;
	localparam logic [1:0] SEL_Y = 2'd1;
	localparam logic [1:0] SEL_Z = 2'd2;
	localparam logic [1:0] SEL_C = 2'd3;

	typedef struct packed {
		logic [1:0]        dst;
		logic              bank;
		logic [3:0]        idx;
		logic [STK_AW-1:0] saddr;
	} mst_tag_t;

	typedef struct packed {
		logic [3:0] idx;
		logic [1:0] p;
		logic [1:0] q;
		logic [1:0] r;
		logic       sub;
	} rot_ent_t;

	function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:  v = 34'sd2949120;
			5'd1:  v = 34'sd1740967;
			5'd2:  v = 34'sd919879;
			5'd3:  v = 34'sd466945;
			5'd4:  v = 34'sd234379;
			5'd5:  v = 34'sd117304;
			5'd6:  v = 34'sd58666;
			5'd7:  v = 34'sd29335;
			5'd8:  v = 34'sd14668;
			5'd9:  v = 34'sd7334;
			5'd10: v = 34'sd3667;
			5'd11: v = 34'sd1833;
			5'd12: v = 34'sd917;
			5'd13: v = 34'sd458;
			5'd14: v = 34'sd229;
			5'd15: v = 34'sd115;
			5'd16: v = 34'sd57;
			5'd17: v = 34'sd29;
			5'd18: v = 34'sd14;
			5'd19: v = 34'sd7;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

	// element = sat(mul(mul(p,q),v) +/- mul(r,s)); r == SEL_C means plain c
	function automatic rot_ent_t rot_entry(input logic [3:0] j);
		rot_ent_t e;
		case (j)
			4'd0: e = '{4'd0,  SEL_X, SEL_X, SEL_C, 1'b0};
			4'd1: e = '{4'd1,  SEL_Y, SEL_X, SEL_Z, 1'b0};
			4'd2: e = '{4'd2,  SEL_Z, SEL_X, SEL_Y, 1'b1};
			4'd3: e = '{4'd4,  SEL_X, SEL_Y, SEL_Z, 1'b1};
			4'd4: e = '{4'd5,  SEL_Y, SEL_Y, SEL_C, 1'b0};
			4'd5: e = '{4'd6,  SEL_Z, SEL_Y, SEL_X, 1'b0};
			4'd6: e = '{4'd8,  SEL_X, SEL_Z, SEL_Y, 1'b0};
			4'd7: e = '{4'd9,  SEL_Y, SEL_Z, SEL_X, 1'b1};
			default: e = '{4'd10, SEL_Z, SEL_Z, SEL_C, 1'b0};
		endcase
		return e;
	endfunction

	function automatic logic signed [31:0] sat_addsub(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic sub);
		logic signed [32:0] s;
		s = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
		if (s[32] != s[31])
			return s[32] ? 32'sh80000000 : 32'sh7fffffff;
		return s[31:0];
	endfunction

	function automatic logic signed [31:0] ident_elem(input logic [3:0] idx);
		return (idx[1:0] == idx[3:2]) ? ONE_Q16 : 32'sd0;
	endfunction

endpackage

/* sv/matrix_stack_transform_unit.sv */
`timescale 1ns / 1ps
// 4x4 Q16.16 modelview matrix stack. One command is taken at a time; in_stall stays high
// until the command's last result is in the output register. The current matrix lives in a
// two-bank memory (a product is written into the idle bank, then the banks swap), the saved
// matrices in a stack memory, and all multiplications go through one pipelined 32x32 MAC.
// Per command: identity, operand load, full push and empty pop go straight to the status
// answer; multiply and translate issue 64 MAC operations; scale issues 12; push and pop
// move one element per cycle; rotate reduces the angle and runs a 20-step CORDIC, builds
// the nine rotation terms (three dependent MAC passes each), then multiplies; read issues
// each element only once the MAC is empty and the output register is free.
module matrix_stack_transform_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         command,
	input  logic [3:0]         element_index,
	input  logic signed [31:0] element_value,
	input  logic signed [31:0] angle_degrees,
	input  logic signed [31:0] vec_x,
	input  logic signed [31:0] vec_y,
	input  logic signed [31:0] vec_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         out_index,
	output logic signed [31:0] out_value,
	output logic [1:0]         status,
	output logic               last
);
	import mst_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CORD  = 4'd1;
	localparam logic [3:0] S_ROT   = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_SCALE = 4'd4;
	localparam logic [3:0] S_XFER  = 4'd5;
	localparam logic [3:0] S_READ  = 4'd6;
	localparam logic [3:0] S_DRAIN = 4'd7;
	localparam logic [3:0] S_ACK   = 4'd8;

	localparam logic [2:0] B_OPD = 3'd0;
	localparam logic [2:0] B_ROT = 3'd1;
	localparam logic [2:0] B_TRN = 3'd2;
	localparam logic [2:0] B_VX  = 3'd3;
	localparam logic [2:0] B_VY  = 3'd4;
	localparam logic [2:0] B_VZ  = 3'd5;
	localparam logic [2:0] B_ONE = 3'd6;

	logic [3:0]        state_q, cmd_q;
	logic [5:0]        cnt_q;
	logic              bank_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [1:0]        st_q;
	logic signed [31:0] vx_q, vy_q, vz_q;

	logic [2*ELEMS-1:0] cval_q;
	logic [ELEMS-1:0]   oval_q;
	logic signed [31:0] cur_mem [2*ELEMS];
	logic signed [31:0] opd_mem [ELEMS];
	logic signed [31:0] rot_mem [ELEMS];
	logic signed [31:0] stk_mem [STACK_DEPTH*ELEMS];

	// issue stage
	logic              iss_vld, iss_first, iss_fin, iss_asel;
	logic [2:0]        iss_bsel;
	logic [3:0]        cur_ridx, src_ridx;
	logic [STK_AW-1:0] stk_addr;
	mst_tag_t          iss_tag;

	logic              iss_vld_s1, first_s1, fin_s1, asel_s1;
	logic [2:0]        bsel_s1;
	logic [3:0]        aidx_s1, bidx_s1;
	mst_tag_t          tag_s1;
	logic signed [31:0] cur_rd_s1, stk_rd_s1, opd_rd_s1, rot_rd_s1;
	logic              cval_s1, oval_s1;
	logic signed [31:0] a_s1, b_s1;

	// rotation terms
	logic [3:0]        j_q;
	logic [1:0]        rstep_q;
	logic              rwait_q;
	logic signed [31:0] s_q, c_q, v_q, t_q, acc_a_q;
	rot_ent_t          ent;
	logic              rot_go;
	logic signed [31:0] rot_a, rot_b;

	logic              mac_vld, mac_first, mac_fin;
	logic signed [31:0] mac_a, mac_b;
	mst_tag_t          mac_tag, res_tag;
	logic              res_vld, mac_busy;
	logic signed [31:0] res_val;

	logic              cord_done;
	logic signed [31:0] cord_s, cord_c;

	logic              accept, busy_all, iss_end, ack_ld, rd_ld, rot_we;
	logic              out_vld_q;
	logic [3:0]        out_idx_q;
	logic signed [31:0] out_val_q;
	logic [1:0]        out_st_q;
	logic              out_last_q;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign busy_all = iss_vld_s1 || mac_busy;
	assign ent      = rot_entry(j_q);

	function automatic logic signed [31:0] pick(input logic [1:0] code,
			input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		case (code)
			SEL_X:   return x;
			SEL_Y:   return y;
			default: return z;
		endcase
	endfunction

	always_comb begin
		iss_vld   = 1'b0;
		iss_first = 1'b1;
		iss_fin   = 1'b1;
		iss_asel  = 1'b0;
		iss_bsel  = B_ONE;
		cur_ridx  = cnt_q[3:0];
		src_ridx  = cnt_q[3:0];
		stk_addr  = STK_AW'({lvl_q, cnt_q[3:0]});
		iss_tag   = '{DST_CUR, bank_q, cnt_q[3:0], stk_addr};
		iss_end   = 1'b0;
		case (state_q)
			S_MUL: begin
				iss_vld   = 1'b1;
				cur_ridx  = {cnt_q[1:0], cnt_q[3:2]};
				src_ridx  = {cnt_q[5:4], cnt_q[1:0]};
				iss_first = (cnt_q[1:0] == 2'd0);
				iss_fin   = (cnt_q[1:0] == 2'd3);
				iss_bsel  = (cmd_q == CMD_MUL) ? B_OPD : ((cmd_q == CMD_ROT) ? B_ROT : B_TRN);
				iss_tag.bank = ~bank_q;
				iss_tag.idx  = cnt_q[5:2];
				iss_end   = (cnt_q == 6'd63);
			end
			S_SCALE: begin
				iss_vld  = 1'b1;
				iss_bsel = (cnt_q[3:2] == 2'd0) ? B_VX : ((cnt_q[3:2] == 2'd1) ? B_VY : B_VZ);
				iss_end  = (cnt_q == 6'd11);
			end
			S_XFER: begin
				iss_vld  = 1'b1;
				iss_asel = (cmd_q == CMD_POP);
				iss_tag.dst = (cmd_q == CMD_POP) ? DST_CUR : DST_STK;
				iss_end  = (cnt_q == 6'd15);
			end
			S_READ: begin
				iss_vld  = !busy_all && !out_vld_q;
				iss_tag.dst = DST_OUT;
				iss_end  = (cnt_q == 6'd15);
			end
			default: ;
		endcase
	end

	always_comb begin
		a_s1 = asel_s1 ? stk_rd_s1 : (cval_s1 ? cur_rd_s1 : ident_elem(aidx_s1));
		case (bsel_s1)
			B_OPD: b_s1 = oval_s1 ? opd_rd_s1 : 32'sd0;
			B_ROT: begin
				if (bidx_s1 == 4'd15)
					b_s1 = ONE_Q16;
				else if (bidx_s1[1:0] == 2'd3 || bidx_s1[3:2] == 2'd3)
					b_s1 = 32'sd0;
				else
					b_s1 = rot_rd_s1;
			end
			B_TRN: begin
				if (bidx_s1 == 4'd12)      b_s1 = vx_q;
				else if (bidx_s1 == 4'd13) b_s1 = vy_q;
				else if (bidx_s1 == 4'd14) b_s1 = vz_q;
				else                       b_s1 = ident_elem(bidx_s1);
			end
			B_VX:    b_s1 = vx_q;
			B_VY:    b_s1 = vy_q;
			B_VZ:    b_s1 = vz_q;
			default: b_s1 = ONE_Q16;
		endcase
	end

	always_comb begin
		rot_go = (state_q == S_ROT) && !rwait_q;
		case (rstep_q)
			2'd0: begin
				rot_a = pick(ent.p, vx_q, vy_q, vz_q);
				rot_b = pick(ent.q, vx_q, vy_q, vz_q);
			end
			2'd1: begin
				rot_a = t_q;
				rot_b = v_q;
			end
			default: begin
				rot_a = (ent.r == SEL_C) ? c_q : pick(ent.r, vx_q, vy_q, vz_q);
				rot_b = (ent.r == SEL_C) ? ONE_Q16 : s_q;
			end
		endcase
		mac_vld   = iss_vld_s1 || rot_go;
		mac_first = rot_go ? 1'b1 : first_s1;
		mac_fin   = rot_go ? 1'b1 : fin_s1;
		mac_a     = rot_go ? rot_a : a_s1;
		mac_b     = rot_go ? rot_b : b_s1;
		mac_tag   = tag_s1;
		if (rot_go)
			mac_tag.dst = DST_REG;
		rot_we = res_vld && (res_tag.dst == DST_REG) && (rstep_q == 2'd2);
		ack_ld = (state_q == S_ACK) && !out_vld_q;
		rd_ld  = res_vld && (res_tag.dst == DST_OUT);
	end

	mst_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (mac_vld),
		.first   (mac_first),
		.fin     (mac_fin),
		.a       (mac_a),
		.b       (mac_b),
		.tag     (mac_tag),
		.res_vld (res_vld),
		.res_tag (res_tag),
		.res_val (res_val),
		.busy    (mac_busy)
	);

	mst_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && command == CMD_ROT),
		.angle   (angle_degrees),
		.done    (cord_done),
		.sin_val (cord_s),
		.cos_val (cord_c)
	);

	// memories: one write and one registered read each per cycle
	always_ff @(posedge clk) begin
		cur_rd_s1 <= cur_mem[{bank_q, cur_ridx}];
		stk_rd_s1 <= stk_mem[stk_addr];
		opd_rd_s1 <= opd_mem[src_ridx];
		rot_rd_s1 <= rot_mem[src_ridx];
		if (res_vld && res_tag.dst == DST_CUR)
			cur_mem[{res_tag.bank, res_tag.idx}] <= res_val;
		if (res_vld && res_tag.dst == DST_STK)
			stk_mem[res_tag.saddr] <= res_val;
		if (accept && command == CMD_LOAD)
			opd_mem[element_index] <= element_value;
		if (rot_we)
			rot_mem[ent.idx] <= sat_addsub(acc_a_q, res_val, ent.sub);
	end

	always_ff @(posedge clk) begin
		cval_s1  <= cval_q[{bank_q, cur_ridx}];
		oval_s1  <= oval_q[src_ridx];
		first_s1 <= iss_first;
		fin_s1   <= iss_fin;
		asel_s1  <= iss_asel;
		bsel_s1  <= iss_bsel;
		aidx_s1  <= cur_ridx;
		bidx_s1  <= src_ridx;
		tag_s1   <= iss_tag;
		if (accept) begin
			cmd_q <= command;
			vx_q  <= vec_x;
			vy_q  <= vec_y;
			vz_q  <= vec_z;
		end
		if (cord_done) begin
			s_q <= cord_s;
			c_q <= cord_c;
			v_q <= ONE_Q16 - cord_c;
		end
		if (res_vld && res_tag.dst == DST_REG) begin
			if (rstep_q == 2'd0) t_q <= res_val;
			if (rstep_q == 2'd1) acc_a_q <= res_val;
		end
		if (ack_ld) begin
			out_idx_q  <= 4'd0;
			out_val_q  <= 32'sd0;
			out_st_q   <= st_q;
			out_last_q <= 1'b1;
		end else if (rd_ld) begin
			out_idx_q  <= res_tag.idx;
			out_val_q  <= res_val;
			out_st_q   <= ST_OK;
			out_last_q <= (res_tag.idx == 4'(ELEMS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			bank_q     <= 1'b0;
			lvl_q      <= '0;
			st_q       <= ST_OK;
			cval_q     <= '0;
			oval_q     <= '0;
			iss_vld_s1 <= 1'b0;
			j_q        <= '0;
			rstep_q    <= '0;
			rwait_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			iss_vld_s1 <= iss_vld;
			if (iss_vld)
				cnt_q <= cnt_q + 6'd1;
			if (res_vld && res_tag.dst == DST_CUR)
				cval_q[{res_tag.bank, res_tag.idx}] <= 1'b1;
			if (ack_ld || rd_ld)
				out_vld_q <= 1'b1;
			else if (out_vld_q && !out_stall)
				out_vld_q <= 1'b0;

			unique case (state_q)
				S_IDLE: if (accept) begin
					cnt_q <= '0;
					st_q  <= ST_OK;
					case (command)
						CMD_IDENT: begin
							if (bank_q)
								cval_q[2*ELEMS-1:ELEMS] <= '0;
							else
								cval_q[ELEMS-1:0] <= '0;
							state_q <= S_ACK;
						end
						CMD_LOAD: begin
							oval_q[element_index] <= 1'b1;
							state_q <= S_ACK;
						end
						CMD_MUL, CMD_TRANS: state_q <= S_MUL;
						CMD_ROT:   state_q <= S_CORD;
						CMD_SCALE: state_q <= S_SCALE;
						CMD_PUSH: begin
							if (lvl_q >= LVL_W'(STACK_DEPTH)) begin
								st_q    <= ST_OVFL;
								state_q <= S_ACK;
							end else
								state_q <= S_XFER;
						end
						CMD_POP: begin
							if (lvl_q == '0) begin
								st_q    <= ST_UNDFL;
								state_q <= S_ACK;
							end else begin
								lvl_q   <= lvl_q - LVL_W'(1);
								state_q <= S_XFER;
							end
						end
						CMD_READ: state_q <= S_READ;
						default:  state_q <= S_ACK;
					endcase
				end
				S_CORD: if (cord_done) begin
					j_q     <= '0;
					rstep_q <= '0;
					rwait_q <= 1'b0;
					state_q <= S_ROT;
				end
				S_ROT: begin
					if (rot_go)
						rwait_q <= 1'b1;
					if (res_vld && res_tag.dst == DST_REG) begin
						rwait_q <= 1'b0;
						if (rstep_q == 2'd2) begin
							rstep_q <= '0;
							j_q     <= j_q + 4'd1;
							if (j_q == 4'd8) begin
								cnt_q   <= '0;
								state_q <= S_MUL;
							end
						end else
							rstep_q <= rstep_q + 2'd1;
					end
				end
				S_MUL, S_SCALE, S_XFER, S_READ: if (iss_vld && iss_end) state_q <= S_DRAIN;
				S_DRAIN: if (!busy_all) begin
					if (cmd_q == CMD_MUL || cmd_q == CMD_TRANS || cmd_q == CMD_ROT)
						bank_q <= ~bank_q;
					if (cmd_q == CMD_PUSH)
						lvl_q <= lvl_q + LVL_W'(1);
					state_q <= (cmd_q == CMD_READ) ? S_IDLE : S_ACK;
				end
				S_ACK: if (ack_ld) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign out_index = out_idx_q;
	assign out_value = out_val_q;
	assign status    = out_st_q;
	assign last      = out_last_q;

	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level out of range");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld && res_tag.dst == DST_OUT) |-> !out_vld_q)
		else $error("read element overwrote a pending transaction");

	a_bank_swap: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_q != $past(bank_q)) |-> ($past(state_q) == S_DRAIN && !$past(busy_all)))
		else $error("bank swapped with writes in flight");

endmodule

/* sv/mst_mac.sv */
`timescale 1ns / 1ps
module mst_mac (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld,
	input  logic                    first,
	input  logic                    fin,
	input  logic signed [31:0]      a,
	input  logic signed [31:0]      b,
	input  mst_pkg::mst_tag_t       tag,
	output logic                    res_vld,
	output mst_pkg::mst_tag_t       res_tag,
	output logic signed [31:0]      res_val,
	output logic                    busy
);
	import mst_pkg::*;

	logic signed [63:0] prod_s1;
	logic               vld_s1, first_s1, fin_s1;
	mst_tag_t           tag_s1;
	logic signed [66:0] acc_s2;
	logic               vld_s2;
	mst_tag_t           tag_s2;
	logic signed [66:0] rnd;
	logic signed [50:0] sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1 && fin_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= a * b;
		first_s1 <= first;
		fin_s1   <= fin;
		tag_s1   <= tag;
		if (vld_s1) begin
			acc_s2 <= first_s1 ? 67'(prod_s1) : acc_s2 + 67'(prod_s1);
			tag_s2 <= tag_s1;
		end
	end

	// round half up, then saturate
	always_comb begin
		rnd = acc_s2 + 67'sd32768;
		sh  = rnd[66:16];
		if (sh > 51'sd2147483647)
			res_val = 32'sh7fffffff;
		else if (sh < -51'sd2147483648)
			res_val = 32'sh80000000;
		else
			res_val = sh[31:0];
	end

	assign res_vld = vld_s2;
	assign res_tag = tag_s2;
	assign busy    = vld_s1 || vld_s2;

endmodule

/* sv/mst_cordic.sv */
`timescale 1ns / 1ps
module mst_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output logic               done,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);
	import mst_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_RED  = 3'd1;
	localparam logic [2:0] PH_FOLD = 3'd2;
	localparam logic [2:0] PH_ITER = 3'd3;
	localparam logic [2:0] PH_OUT  = 3'd4;

	logic [2:0]         ph_q;
	logic [2:0]         k_q;
	logic [4:0]         i_q;
	logic signed [33:0] a_q, x_q, y_q, z_q;
	logic               neg_q, done_q;
	logic signed [31:0] sin_q, cos_q;

	logic signed [33:0] sub_v, r1, dx, dy, at, cq, sq;

	always_comb begin
		sub_v = FULL_TURN <<< k_q;
		r1    = (a_q > HALF_TURN) ? a_q - FULL_TURN : a_q;
		dx    = y_q >>> i_q;
		dy    = x_q >>> i_q;
		at    = atan_deg(i_q);
		cq    = (x_q + 34'sd8192) >>> 14;
		sq    = (y_q + 34'sd8192) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ph_q)
				PH_IDLE: if (start) ph_q <= PH_RED;
				PH_RED:  if (k_q == 3'd0) ph_q <= PH_FOLD;
				PH_FOLD: ph_q <= PH_ITER;
				PH_ITER: if (i_q == 5'(CORDIC_STEPS - 1)) ph_q <= PH_OUT;
				PH_OUT: begin
					ph_q   <= PH_IDLE;
					done_q <= 1'b1;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				// bias negative angles up by 128 turns; restoring steps bring it to [0, turn)
				a_q <= (angle < 0) ? 34'(angle) + (FULL_TURN <<< 7) : 34'(angle);
				k_q <= 3'd6;
			end
			PH_RED: begin
				if (a_q >= sub_v)
					a_q <= a_q - sub_v;
				k_q <= k_q - 3'd1;
			end
			PH_FOLD: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				i_q <= '0;
				if (r1 > QUARTER_TURN) begin
					z_q   <= r1 - HALF_TURN;
					neg_q <= 1'b1;
				end else if (r1 < -QUARTER_TURN) begin
					z_q   <= r1 + HALF_TURN;
					neg_q <= 1'b1;
				end else begin
					z_q   <= r1;
					neg_q <= 1'b0;
				end
			end
			PH_ITER: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				i_q <= i_q + 5'd1;
			end
			PH_OUT: begin
				cos_q <= neg_q ? 32'(-cq) : 32'(cq);
				sin_q <= neg_q ? 32'(-sq) : 32'(sq);
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule
